// ===== rtl/maf_pkg.sv =====
`timescale 1ns / 1ps

package maf_pkg;

	localparam int TABLE_ENTRIES_DEF = 1024;
	localparam int ADDR_W = 32;
	localparam int KEEP_W = 4;
	localparam int MODE_W = 2;
	localparam int STATUS_W = 2;
	localparam int SLOT_W = 10;
	localparam int ENTRY_W = 1 + KEEP_W + ADDR_W;

	localparam logic [MODE_W-1:0] MODE_CHECK = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

	function automatic logic [ADDR_W-1:0] expand_keep(input logic [KEEP_W-1:0] keep);
		logic [ADDR_W-1:0] m;
		m = '0;
		for (int i = 0; i < KEEP_W; i++) begin
			if (keep[i]) begin
				m[8*i +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

endpackage

// ===== rtl/maf_ram.sv =====
`timescale 1ns / 1ps

module maf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/masked_address_filter_table_unit.sv =====
`timescale 1ns / 1ps

// address filter table with per-octet masks
// request channel: in_valid/in_ready with mode, address, octet_keep
// result channel: out_valid/out_ready with reject, status, slot
// config channel: cfg_valid/cfg_ready with cfg_data -> ban_mode, always ready
// entries live in one ram with a registered read; a request scans
// the slots from 0 upward, one ram read per cycle, and stops at the first hit
// a request stops at the slot of its hit; a miss or a full table scans every
// slot, and an unused mode goes to the result with no scan
// one request is in work at a time; the next one is taken once the result has
// moved to the output register, even while that result still waits
// reset: ban_mode goes to 1 and a clearing pass writes every slot free;
// in_ready stays low until it ends, cfg writes are taken
// a stalled receiver holds the result in the output register; a finished
// request then waits in the block and the next request is not taken
module masked_address_filter_table_unit
	import maf_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [MODE_W-1:0]   mode,
	input  logic [ADDR_W-1:0]   address,
	input  logic [KEEP_W-1:0]   octet_keep,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                reject,
	output logic [STATUS_W-1:0] status,
	output logic [SLOT_W-1:0]   slot,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_ENTRIES);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	typedef enum logic [3:0] {
		S_CLEAR  = 4'b0001,
		S_IDLE   = 4'b0010,
		S_SCAN   = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] rd_q;
	logic vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [MODE_W-1:0] mode_q;
	logic [ADDR_W-1:0] addr_q;
	logic [KEEP_W-1:0] keep_q;
	logic ban_mode_q;
	logic res_reject_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic out_valid_q;
	logic reject_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0] slot_q;

	logic ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic ram_re;
	logic [ENTRY_W-1:0] ram_rdata;

	logic r_valid;
	logic [KEEP_W-1:0] r_octets;
	logic [ADDR_W-1:0] r_compare;
	logic [ADDR_W-1:0] req;
	logic hit;
	logic last;
	logic out_free;
	logic [SLOT_W-1:0] hit_slot;
	logic res_reject_d;
	logic [STATUS_W-1:0] res_status_d;

	assign r_valid = ram_rdata[ENTRY_W-1];
	assign r_octets = ram_rdata[ADDR_W +: KEEP_W];
	assign r_compare = ram_rdata[ADDR_W-1:0];
	assign req = addr_q & expand_keep(keep_q);
	assign hit_slot = SLOT_W'(idx_s1);

	always_comb begin
		hit = 1'b0;
		if (vld_s1) begin
			case (mode_q)
				MODE_CHECK: hit = r_valid && ((addr_q & expand_keep(r_octets)) == r_compare);
				MODE_ADD: hit = !r_valid;
				MODE_REMOVE: hit = r_valid && (r_octets == keep_q) && (r_compare == req);
				default: hit = 1'b0;
			endcase
		end
	end

	always_comb begin
		res_reject_d = 1'b0;
		res_status_d = ST_DONE;
		case (mode_q)
			MODE_CHECK: res_reject_d = hit ? ban_mode_q : !ban_mode_q;
			MODE_ADD: res_status_d = hit ? ST_DONE : ST_FULL;
			MODE_REMOVE: res_status_d = hit ? ST_DONE : ST_NOT_FOUND;
			default: res_status_d = ST_DONE;
		endcase
	end

	assign last = vld_s1 && (idx_s1 == LAST_IDX);
	assign ram_re = (state_q == S_SCAN) && !(hit || last) && (rd_q < CNT_END);

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = rd_q[IDX_W-1:0];
		ram_wdata = '0;
		if (state_q == S_CLEAR) begin
			ram_we = 1'b1;
		end else if (state_q == S_SCAN && hit) begin
			ram_waddr = idx_s1;
			if (mode_q == MODE_ADD) begin
				ram_we = 1'b1;
				ram_wdata = {1'b1, keep_q, req};
			end else if (mode_q == MODE_REMOVE) begin
				ram_we = 1'b1;
				ram_wdata = {1'b0, ram_rdata[ENTRY_W-2:0]};
			end
		end
	end

	maf_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES),
		.AW   (IDX_W)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(rd_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			rd_q <= '0;
			vld_s1 <= 1'b0;
			ban_mode_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ban_mode_q <= cfg_data;
			end
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			vld_s1 <= ram_re;
			case (state_q)
				S_CLEAR: begin
					rd_q <= rd_q + CNT_ONE;
					if (rd_q[IDX_W-1:0] == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						rd_q <= '0;
						if (mode inside {MODE_CHECK, MODE_ADD, MODE_REMOVE}) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_SCAN: begin
					if (ram_re) begin
						rd_q <= rd_q + CNT_ONE;
					end
					if (hit || last) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_q[IDX_W-1:0];
		if (state_q == S_IDLE && in_valid) begin
			mode_q <= mode;
			addr_q <= address;
			keep_q <= octet_keep;
			res_reject_q <= 1'b0;
			res_status_q <= ST_DONE;
			res_slot_q <= '0;
		end
		if (state_q == S_SCAN && (hit || last)) begin
			res_slot_q <= hit ? hit_slot : '0;
			res_reject_q <= res_reject_d;
			res_status_q <= res_status_d;
		end
		if (state_q == S_FINISH && out_free) begin
			reject_q <= res_reject_q;
			status_q <= res_status_q;
			slot_q <= res_slot_q;
		end
	end

	assign out_valid = out_valid_q;
	assign reject = reject_q;
	assign status = status_q;
	assign slot = slot_q;

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_FINISH) |-> !ram_we)
		else $error("table written outside clear or scan");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request taken while another is in work");

	a_write_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q == S_SCAN) |=> (state_q == S_FINISH))
		else $error("scan continued after a table write");

	a_error_no_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_DONE) |-> !reject)
		else $error("reject set on a failed add or remove");

endmodule
